// ----- hw/rtl/bor_pkg.sv -----
// Package for the box overlap ratio unit.
// Holds the default widths shared by the interfaces, the top level and the checker.
package bor_pkg;

    // Default width of a box coordinate, width or height.
    localparam int COORD_BITS_DEF = 12;

    // Default number of fraction bits of a ratio; 2**FRAC_BITS means 1.0.
    localparam int FRAC_BITS_DEF  = 16;

endpackage : bor_pkg

// ----- hw/rtl/box_req_if.sv -----
// Request channel of the box overlap ratio unit: valid/ready and one box pair.
// Depends on bor_pkg for the default coordinate width.
interface box_req_if
    import bor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] ref_x;
    logic [COORD_BITS-1:0] ref_y;
    logic [COORD_BITS-1:0] ref_w;
    logic [COORD_BITS-1:0] ref_h;
    logic [COORD_BITS-1:0] cand_x;
    logic [COORD_BITS-1:0] cand_y;
    logic [COORD_BITS-1:0] cand_w;
    logic [COORD_BITS-1:0] cand_h;

    modport source (
        output valid, ref_x, ref_y, ref_w, ref_h, cand_x, cand_y, cand_w, cand_h,
        input  ready
    );

    modport sink (
        input  valid, ref_x, ref_y, ref_w, ref_h, cand_x, cand_y, cand_w, cand_h,
        output ready
    );
endinterface : box_req_if

// ----- hw/rtl/box_rsp_if.sv -----
// Result channel of the box overlap ratio unit: valid/ready and the two ratios.
// Depends on bor_pkg for the default fraction width.
interface box_rsp_if
    import bor_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] iou_ratio;
    logic [FRAC_BITS:0] ref_cover_ratio;
    logic               boxes_overlap;

    modport source (
        output valid, iou_ratio, ref_cover_ratio, boxes_overlap,
        input  ready
    );

    modport sink (
        input  valid, iou_ratio, ref_cover_ratio, boxes_overlap,
        output ready
    );
endinterface : box_rsp_if

// ----- hw/rtl/box_overlap_ratio_unit.sv -----
// Box overlap ratio unit: pipelined intersection-over-union of two pixel boxes.
// Depends on bor_pkg, box_req_if and box_rsp_if.
//
// Takes one request (reference box plus candidate box) per cycle unless the last
// stage holds a result not yet taken, and returns one result per request, in order.
// Three front stages compute the overlap extents, the three areas and the union;
// then two restoring dividers run side by side, one quotient bit per stage, for
// FRAC_BITS+1 stages, and that divider chain sets the latency. A single pipeline
// enable holds every stage while the last one waits, so ready follows the result
// side within the same cycle. Ratios are unsigned Q1.FRAC_BITS truncated toward
// zero; both are zero when the boxes do not overlap.
module box_overlap_ratio_unit
    import bor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    box_req_if.sink   i_req,
    box_rsp_if.source o_rsp
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = 2 * CW;        // area width
    localparam int UW   = AW + 1;        // union width, also divider remainder width
    localparam int QW   = FRAC_BITS + 1; // quotient width
    localparam int NDIV = QW;            // one quotient bit per divider stage
    localparam int NST  = 3 + NDIV;      // total pipeline stages

    // Pipeline enable: advance unless the last stage holds a result not yet taken.
    logic           pipe_en;
    logic [NST-1:0] r_vld;

    assign pipe_en     = !r_vld[NST-1] || o_rsp.ready;
    assign i_req.ready = pipe_en;

    // Shift valid bits along with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[NST-2:0], i_req.valid};
        end
    end

    // ---------------- Stage 1: overlap extents ----------------
    logic [CW:0]   end_rx, end_cx, end_ry, end_cy;
    logic [CW-1:0] lo_x, lo_y;
    logic [CW:0]   hi_x, hi_y;
    logic [CW:0]   len_x, len_y;
    logic          ov_x, ov_y;

    always_comb begin
        // Exclusive end columns and rows at full precision.
        end_rx = {1'b0, i_req.ref_x}  + {1'b0, i_req.ref_w};
        end_cx = {1'b0, i_req.cand_x} + {1'b0, i_req.cand_w};
        end_ry = {1'b0, i_req.ref_y}  + {1'b0, i_req.ref_h};
        end_cy = {1'b0, i_req.cand_y} + {1'b0, i_req.cand_h};
        lo_x   = (i_req.ref_x > i_req.cand_x) ? i_req.ref_x : i_req.cand_x;
        lo_y   = (i_req.ref_y > i_req.cand_y) ? i_req.ref_y : i_req.cand_y;
        hi_x   = (end_rx < end_cx) ? end_rx : end_cx;
        hi_y   = (end_ry < end_cy) ? end_ry : end_cy;
        ov_x   = hi_x > {1'b0, lo_x};
        ov_y   = hi_y > {1'b0, lo_y};
        len_x  = hi_x - {1'b0, lo_x};
        len_y  = hi_y - {1'b0, lo_y};
    end

    logic [CW-1:0] r_s1_iw, r_s1_ih;
    logic [CW-1:0] r_s1_rw, r_s1_rh, r_s1_cw, r_s1_ch;
    logic          r_s1_ov;

    // Capture overlap lengths; force zero lengths when the boxes miss.
    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_ov <= ov_x && ov_y;
            r_s1_iw <= (ov_x && ov_y) ? len_x[CW-1:0] : '0;
            r_s1_ih <= (ov_x && ov_y) ? len_y[CW-1:0] : '0;
            r_s1_rw <= i_req.ref_w;
            r_s1_rh <= i_req.ref_h;
            r_s1_cw <= i_req.cand_w;
            r_s1_ch <= i_req.cand_h;
        end
    end

    // ---------------- Stage 2: areas ----------------
    logic [AW-1:0] r_s2_inter, r_s2_ra, r_s2_ca;
    logic          r_s2_ov;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s2_ov    <= r_s1_ov;
            r_s2_inter <= AW'(r_s1_iw) * AW'(r_s1_ih);
            r_s2_ra    <= AW'(r_s1_rw) * AW'(r_s1_rh);
            r_s2_ca    <= AW'(r_s1_cw) * AW'(r_s1_ch);
        end
    end

    // ---------------- Stage 3: union ----------------
    logic [UW-1:0] r_s3_uni;
    logic [AW-1:0] r_s3_inter, r_s3_ra;
    logic          r_s3_ov;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s3_ov    <= r_s2_ov;
            r_s3_inter <= r_s2_inter;
            r_s3_ra    <= r_s2_ra;
            r_s3_uni   <= {1'b0, r_s2_ra} + {1'b0, r_s2_ca} - {1'b0, r_s2_inter};
        end
    end

    // ---------------- Divider stages ----------------
    // Restoring division of (inter << FRAC_BITS) by union and by reference area.
    // Stage 0 yields the integer bit, each later stage one more fraction bit.
    logic [UW-1:0] r_dv_iu_rem [NDIV];
    logic [UW-1:0] r_dv_rc_rem [NDIV];
    logic [QW-1:0] r_dv_iu_q   [NDIV];
    logic [QW-1:0] r_dv_rc_q   [NDIV];
    logic [UW-1:0] r_dv_uni    [NDIV];
    logic [UW-1:0] r_dv_ra     [NDIV];
    logic          r_dv_ov     [NDIV];

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        logic [UW:0]   cur_iu, cur_rc;
        logic [UW-1:0] d_iu, d_rc;
        logic [QW-1:0] q_iu_in, q_rc_in;
        logic          ov_in;
        logic          ge_iu, ge_rc;
        logic [UW:0]   n_iu_rem, n_rc_rem;

        // Select the partial remainder: the dividend itself, or the last one doubled.
        if (k == 0) begin : g_first
            always_comb begin
                cur_iu  = {2'b00, r_s3_inter};
                cur_rc  = {2'b00, r_s3_inter};
                d_iu    = r_s3_uni;
                d_rc    = {1'b0, r_s3_ra};
                q_iu_in = '0;
                q_rc_in = '0;
                ov_in   = r_s3_ov;
            end
        end else begin : g_next
            always_comb begin
                cur_iu  = {r_dv_iu_rem[k-1], 1'b0};
                cur_rc  = {r_dv_rc_rem[k-1], 1'b0};
                d_iu    = r_dv_uni[k-1];
                d_rc    = r_dv_ra[k-1];
                q_iu_in = r_dv_iu_q[k-1];
                q_rc_in = r_dv_rc_q[k-1];
                ov_in   = r_dv_ov[k-1];
            end
        end

        // Compare and subtract for one quotient bit on each path.
        always_comb begin
            ge_iu    = cur_iu >= {1'b0, d_iu};
            ge_rc    = cur_rc >= {1'b0, d_rc};
            n_iu_rem = ge_iu ? (cur_iu - {1'b0, d_iu}) : cur_iu;
            n_rc_rem = ge_rc ? (cur_rc - {1'b0, d_rc}) : cur_rc;
        end

        always_ff @(posedge i_clk) begin
            if (pipe_en) begin
                r_dv_iu_rem[k] <= n_iu_rem[UW-1:0];
                r_dv_rc_rem[k] <= n_rc_rem[UW-1:0];
                r_dv_iu_q[k]   <= {q_iu_in[QW-2:0], ge_iu};
                r_dv_rc_q[k]   <= {q_rc_in[QW-2:0], ge_rc};
                r_dv_uni[k]    <= d_iu;
                r_dv_ra[k]     <= d_rc;
                r_dv_ov[k]     <= ov_in;
            end
        end
    end

    // ---------------- Result ----------------
    // Drop the quotients of a pair that does not overlap.
    assign o_rsp.valid           = r_vld[NST-1];
    assign o_rsp.boxes_overlap   = r_dv_ov[NDIV-1];
    assign o_rsp.iou_ratio       = r_dv_ov[NDIV-1] ? r_dv_iu_q[NDIV-1] : '0;
    assign o_rsp.ref_cover_ratio = r_dv_ov[NDIV-1] ? r_dv_rc_q[NDIV-1] : '0;

endmodule : box_overlap_ratio_unit

// ----- hw/rtl/bor_checker.sv -----
// Port-level checker for the box overlap ratio unit, bound to the top level.
// Depends on bor_pkg for the default fraction width.
module bor_checker
    import bor_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FRAC_BITS:0] i_iou_ratio,
    input logic [FRAC_BITS:0] i_ref_cover_ratio,
    input logic               i_boxes_overlap
);

    localparam logic [FRAC_BITS:0] RATIO_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_iou_ratio)
            && $stable(i_ref_cover_ratio) && $stable(i_boxes_overlap))
        else $error("stalled result changed");

    // No result right after reset.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A disjoint pair reports zero ratios.
    a_zero_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_boxes_overlap |-> i_iou_ratio == '0 && i_ref_cover_ratio == '0)
        else $error("nonzero ratio without overlap");

    // Ratios never pass one, and union never falls below the reference area.
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_iou_ratio <= RATIO_ONE && i_ref_cover_ratio <= RATIO_ONE
            && i_iou_ratio <= i_ref_cover_ratio)
        else $error("ratio out of range");

endmodule : bor_checker

bind box_overlap_ratio_unit bor_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_bor_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_iou_ratio       (o_rsp.iou_ratio),
    .i_ref_cover_ratio (o_rsp.ref_cover_ratio),
    .i_boxes_overlap   (o_rsp.boxes_overlap)
);

// ----- tb/box_ratio_checker.sv -----
`timescale 1ns / 100ps
// Checker for the box overlap ratio unit: watches the request and result channels,
// predicts the ratios of every accepted box pair and compares them in order.
// Depends on bor_pkg, box_req_if and box_rsp_if.
module box_ratio_checker
    import bor_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    box_req_if   i_req,
    box_rsp_if   i_rsp,
    output int   o_error_count,
    output int   o_pending
);

    typedef struct {
        logic [FRAC_BITS:0] iou;
        logic [FRAC_BITS:0] ref_part;
        logic               overlap;
    } t_ratio_result;

    // Ratios owed for requests that have gone in but not come out yet
    t_ratio_result expected_ratios_q[$];
    int            result_index;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        result_index  = 0;
    end

    // Length of the overlap of two inclusive spans; zero or negative when disjoint
    function automatic longint overlap_span(input longint a0, input longint a_len,
                                            input longint b0, input longint b_len);
        longint lo;
        longint hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + a_len) < (b0 + b_len)) ? (a0 + a_len - 1) : (b0 + b_len - 1);
        return hi - lo + 1;
    endfunction

    // Intersection over union and over reference area, Q1.FRAC_BITS truncated
    function automatic t_ratio_result predict_ratios(
        input logic [COORD_BITS-1:0] rx, input logic [COORD_BITS-1:0] ry,
        input logic [COORD_BITS-1:0] rw, input logic [COORD_BITS-1:0] rh,
        input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
        input logic [COORD_BITS-1:0] cw, input logic [COORD_BITS-1:0] ch
    );
        longint          span_w;
        longint          span_h;
        longint unsigned inter_area;
        longint unsigned ref_area;
        longint unsigned cand_area;
        longint unsigned union_area;
        longint unsigned scaled;
        t_ratio_result   r;
        r.iou      = '0;
        r.ref_part = '0;
        r.overlap  = 1'b0;
        span_w = overlap_span(longint'(rx), longint'(rw), longint'(cx), longint'(cw));
        span_h = overlap_span(longint'(ry), longint'(rh), longint'(cy), longint'(ch));
        if (span_w > 0 && span_h > 0) begin
            inter_area = span_w * span_h;
            ref_area   = longint'(rw) * longint'(rh);
            cand_area  = longint'(cw) * longint'(ch);
            union_area = ref_area + cand_area - inter_area;
            scaled     = inter_area << FRAC_BITS;
            r.iou      = (FRAC_BITS + 1)'(scaled / union_area);
            r.ref_part = (FRAC_BITS + 1)'(scaled / ref_area);
            r.overlap  = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: result %0d mismatch: %s", $time, result_index, msg);
        o_error_count++;
    endtask

    // Queue a prediction per accepted request, compare each accepted result
    always @(posedge i_clk) begin : track_ratios
        t_ratio_result want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                expected_ratios_q.push_back(predict_ratios(
                    i_req.ref_x, i_req.ref_y, i_req.ref_w, i_req.ref_h,
                    i_req.cand_x, i_req.cand_y, i_req.cand_w, i_req.cand_h));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_ratios_q.size() == 0) begin
                    report_mismatch("result with no request outstanding");
                end else begin
                    want = expected_ratios_q.pop_front();
                    if (i_rsp.iou_ratio !== want.iou)
                        report_mismatch($sformatf("iou_ratio got %0d expected %0d",
                                                  i_rsp.iou_ratio, want.iou));
                    if (i_rsp.ref_cover_ratio !== want.ref_part)
                        report_mismatch($sformatf("ref_cover_ratio got %0d expected %0d",
                                                  i_rsp.ref_cover_ratio, want.ref_part));
                    if (i_rsp.boxes_overlap !== want.overlap)
                        report_mismatch($sformatf("boxes_overlap got %b expected %b",
                                                  i_rsp.boxes_overlap, want.overlap));
                end
                result_index++;
            end
        end
        o_pending = expected_ratios_q.size();
    end

endmodule : box_ratio_checker

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the box overlap ratio unit testbench: clock, reset, box pair requests and
// result back-pressure, with the verdict. Depends on bor_pkg, the two channel
// interfaces, box_overlap_ratio_unit and box_ratio_checker.
module testbench;
    import bor_pkg::*;

    localparam int COORD_MAX       = (1 << COORD_BITS_DEF) - 1;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int QUIET_LIMIT     = 3000;

    typedef enum logic [1:0] {
        TRAFFIC_BURSTY,
        TRAFFIC_HOLD,
        TRAFFIC_STREAM
    } t_traffic;

    logic     i_clk;
    logic     i_rst_n;
    t_traffic traffic;
    bit       hold_off_req;
    int       mismatch_count;
    int       ratios_pending;
    int       quiet_cycles;

    box_req_if #(.COORD_BITS(COORD_BITS_DEF)) req_if ();
    box_rsp_if #(.FRAC_BITS(FRAC_BITS_DEF))   rsp_if ();

    box_overlap_ratio_unit #(
        .COORD_BITS(COORD_BITS_DEF),
        .FRAC_BITS (FRAC_BITS_DEF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    box_ratio_checker #(
        .COORD_BITS(COORD_BITS_DEF),
        .FRAC_BITS (FRAC_BITS_DEF)
    ) ratio_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_error_count(mismatch_count),
        .o_pending    (ratios_pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offer one box pair from a falling edge; hold it until a rising edge accepts it
    task automatic send_pair(
        input int rx, input int ry, input int rw, input int rh,
        input int cx, input int cy, input int cw, input int ch
    );
        if (traffic == TRAFFIC_BURSTY && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.ref_x  <= COORD_BITS_DEF'(rx);
        req_if.ref_y  <= COORD_BITS_DEF'(ry);
        req_if.ref_w  <= COORD_BITS_DEF'(rw);
        req_if.ref_h  <= COORD_BITS_DEF'(rh);
        req_if.cand_x <= COORD_BITS_DEF'(cx);
        req_if.cand_y <= COORD_BITS_DEF'(cy);
        req_if.cand_w <= COORD_BITS_DEF'(cw);
        req_if.cand_h <= COORD_BITS_DEF'(ch);
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly small boxes, now and then frame-sized ones
    function automatic int pick_size();
        case ($urandom_range(0, 7))
            0: return $urandom_range(1, COORD_MAX);
            1: return $urandom_range(COORD_MAX - 255, COORD_MAX);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    // Random pairs: mostly overlapping, some identical, the rest anywhere in the frame
    task automatic run_random(input int count);
        int rx, ry, rw, rh, cx, cy, cw, ch;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            rx = $urandom_range(0, COORD_MAX);
            ry = $urandom_range(0, COORD_MAX);
            rw = pick_size();
            rh = pick_size();
            cw = pick_size();
            ch = pick_size();
            if (kind <= 5) begin
                cx = rx + int'($urandom_range(0, rw - 1)) - int'($urandom_range(0, cw - 1));
                cy = ry + int'($urandom_range(0, rh - 1)) - int'($urandom_range(0, ch - 1));
                if (cx < 0) cx = 0;
                if (cx > COORD_MAX) cx = COORD_MAX;
                if (cy < 0) cy = 0;
                if (cy > COORD_MAX) cy = COORD_MAX;
            end else if (kind == 6) begin
                cx = rx;
                cy = ry;
                cw = rw;
                ch = rh;
            end else begin
                cx = $urandom_range(0, COORD_MAX);
                cy = $urandom_range(0, COORD_MAX);
            end
            send_pair(rx, ry, rw, rh, cx, cy, cw, ch);
        end
    endtask

    // Result side: random stall bursts, one long hold-off on request, none at the end
    initial begin : result_sink
        rsp_if.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                rsp_if.ready <= 1'b1;
                hold_off_req = 1'b0;
                @(negedge i_clk);
            end else if (traffic == TRAFFIC_BURSTY && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                rsp_if.ready <= 1'b1;
                @(negedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("box_overlap_ratio_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        traffic       = TRAFFIC_BURSTY;
        hold_off_req  = 1'b0;
        req_if.valid  = 1'b0;
        req_if.ref_x  = '0;
        req_if.ref_y  = '0;
        req_if.ref_w  = '0;
        req_if.ref_h  = '0;
        req_if.cand_x = '0;
        req_if.cand_y = '0;
        req_if.cand_w = '0;
        req_if.cand_h = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Identical boxes: smallest, frame-sized, and reaching past the frame edge
        send_pair(0, 0, 1, 1, 0, 0, 1, 1);
        send_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095);
        send_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
        // Touching but disjoint, then a single shared corner pixel
        send_pair(0, 0, 10, 10, 10, 0, 10, 10);
        send_pair(0, 0, 10, 10, 0, 10, 10, 10);
        send_pair(0, 0, 10, 10, 9, 9, 10, 10);
        // One box inside the other, both ways round
        send_pair(100, 100, 100, 100, 110, 110, 10, 10);
        send_pair(110, 110, 10, 10, 100, 100, 100, 100);
        // Overlap so small that the union ratio truncates to zero
        send_pair(0, 0, 4095, 4095, 4094, 4094, 1, 1);
        send_pair(4094, 4094, 1, 1, 0, 0, 4095, 4095);
        // One third
        send_pair(0, 0, 2, 1, 1, 0, 2, 1);
        // Extents past the frame edge: adjacent, then one shared column
        send_pair(4095, 0, 4095, 1, 0, 0, 4095, 1);
        send_pair(4095, 0, 4095, 1, 4094, 0, 2, 1);
        // Alternating bit patterns
        send_pair('hAAA, 'h555, 'h555, 'hAAA, 'h555, 'hAAA, 'hAAA, 'h555);
        send_pair('h555, 'hAAA, 'hAAA, 'h555, 'hAAA, 'h555, 'h555, 'hAAA);
        // Thin boxes: shared pixel at the bottom edge, and a cross
        send_pair(0, 4095, 1, 4095, 0, 4095, 1, 1);
        send_pair(2000, 0, 1, 4095, 0, 2000, 4095, 1);

        run_random(260);

        // Stall the result side for a long stretch while requests keep coming
        traffic      = TRAFFIC_HOLD;
        hold_off_req = 1'b1;
        run_random(60);

        traffic = TRAFFIC_STREAM;
        run_random(80);
        req_if.valid <= 1'b0;

        wait (ratios_pending == 0);
        repeat (FRAC_BITS_DEF + 8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("box_overlap_ratio_unit regression: pass");
        end else begin
            $display("box_overlap_ratio_unit regression: fail");
        end
        $finish;
    end

endmodule : testbench
